@@ rtl/plpl_pkg.sv @@
// shared types and constants of the piecewise linear position lookup core
// no dependencies; imported by every module of the block
package plpl_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
    localparam int KEY_W        = 64;
    localparam int WIDE_W       = 128;
    localparam int POS_W        = 32;
    localparam int SEG_CNT_W    = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int HALF_W       = 32;
    localparam int MUL_STEPS    = 4;
    localparam int MUL_CNT_W    = 3;
    localparam int FRAC_Q       = 16;
    localparam int PROD_SHIFT   = 32;
    localparam int IN_TDATA_W   = 264;
    localparam int OUT_TDATA_W  = 64;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWEST_KEY    = 3'd0,
        CFG_HIGHEST_KEY   = 3'd1,
        CFG_POS_COUNT     = 3'd2,
        CFG_ERROR_BOUND   = 3'd3,
        CFG_HALVE_MODE    = 3'd4,
        CFG_SEGMENT_COUNT = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_FETCH,
        ST_MUL,
        ST_NEG,
        ST_SHADD,
        ST_LOWER,
        ST_UPPER,
        ST_CLAMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] intercept;
        logic [KEY_W-1:0] slope;
        logic [KEY_W-1:0] start_key;
    } seg_row_t;

    typedef struct packed {
        logic [HALF_W-1:0] mul_a;
        logic [HALF_W-1:0] mul_b;
        logic [WIDE_W-1:0] add_a;
        logic [WIDE_W-1:0] add_b;
        logic              add_cin;
    } arith_req_t;

    typedef struct packed {
        logic [2*HALF_W-1:0] mul_p;
        logic [WIDE_W-1:0]   add_sum;
    } arith_rsp_t;

endpackage

@@ rtl/piecewise_linear_position_lookup_core.sv @@
// piecewise linear position lookup: binary search over a segment table, then a
// fixed point multiply-add and window clamp on one shared multiplier and adder
// a load writes its row straight into the table; a key outside the bounds skips the search
// and the arithmetic; a lookup in range runs the binary search (at most 8 steps for 256
// segments, one table read per step), the multiply-add and the clamp; the next item is
// taken once the result has moved to the output register, later while that register waits
// on m_tready. reset (aresetn, synchronous) loads the register defaults; the segment
// table is not cleared and holds junk until loaded
module piecewise_linear_position_lookup_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: entry_index[7:0], entry_start_key[71:8], entry_slope[135:72],
    //        entry_intercept[199:136], lookup_key[263:200]
    input  logic [plpl_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: op[0]
    input  logic                                s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: window_low[31:0], window_high[63:32]
    output logic [plpl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [plpl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plpl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import plpl_pkg::*;

    // input item fields
    logic [SEG_AW-1:0] in_entry_index;
    seg_row_t          in_row;
    logic [KEY_W-1:0]  in_lookup_key;

    assign in_entry_index   = s_tdata[7:0];
    assign in_row.start_key = s_tdata[71:8];
    assign in_row.slope     = s_tdata[135:72];
    assign in_row.intercept = s_tdata[199:136];
    assign in_lookup_key    = s_tdata[263:200];

    // configuration registers
    logic [KEY_W-1:0]     lowest_key_reg;
    logic [KEY_W-1:0]     highest_key_reg;
    logic [POS_W-1:0]     pos_count_reg;
    logic [POS_W-1:0]     error_bound_reg;
    logic                 halve_mode_reg;
    logic [SEG_CNT_W-1:0] seg_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_key_reg  <= '0;
            highest_key_reg <= '1;
            pos_count_reg   <= POS_W'(1);
            error_bound_reg <= '0;
            halve_mode_reg  <= 1'b0;
            seg_count_reg   <= SEG_CNT_W'(2);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOWEST_KEY:    lowest_key_reg  <= cfg_wdata;
                CFG_HIGHEST_KEY:   highest_key_reg <= cfg_wdata;
                CFG_POS_COUNT:     pos_count_reg   <= cfg_wdata[POS_W-1:0];
                CFG_ERROR_BOUND:   error_bound_reg <= cfg_wdata[POS_W-1:0];
                CFG_HALVE_MODE:    halve_mode_reg  <= cfg_wdata[0];
                CFG_SEGMENT_COUNT: seg_count_reg   <= cfg_wdata[SEG_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SEG_AW-1:0]   left_reg, left_next;
    logic [SEG_AW-1:0]   right_reg, right_next;
    logic [SEG_AW-1:0]   mid_reg, mid_next;
    logic                neg_reg, neg_next;
    logic [KEY_W-1:0]    mag_reg, mag_next;
    logic [KEY_W-1:0]    icpt_reg, icpt_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [2*HALF_W-1:0] pp_reg, pp_next;
    logic [1:0]          pp_shift_reg, pp_shift_next;
    logic [WIDE_W-1:0]   acc_reg, acc_next;
    logic [WIDE_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]    res_low_reg, res_low_next;
    logic [POS_W-1:0]    res_high_reg, res_high_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // segment table
    logic              mem_we;
    logic [SEG_AW-1:0] rd_addr;
    seg_row_t          rd_row;

    assign mem_we = s_tvalid && s_tready && (s_tuser == OP_LOAD);

    plpl_seg_mem u_seg_mem (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (in_entry_index),
        .wr_row  (in_row),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    // shared multiplier and adder
    arith_req_t arith_req;
    arith_rsp_t arith_rsp;

    plpl_arith_unit u_arith (
        .req (arith_req),
        .rsp (arith_rsp)
    );

    // search helpers
    logic [SEG_AW-1:0] last_idx;
    logic              go_left;
    logic [SEG_AW-1:0] l_new, r_new, mid_new;
    logic [SEG_AW:0]   lr_sum;

    always_comb begin
        if (seg_count_reg < SEG_CNT_W'(2)) begin
            last_idx = SEG_AW'(1);
        end else if (32'(seg_count_reg) > MAX_SEGMENTS) begin
            last_idx = SEG_AW'(MAX_SEGMENTS - 1);
        end else begin
            last_idx = SEG_AW'(seg_count_reg - SEG_CNT_W'(1));
        end
        go_left = key_reg < rd_row.start_key;
        l_new   = go_left ? left_reg : mid_reg;
        r_new   = go_left ? mid_reg : right_reg;
        lr_sum  = {1'b0, l_new} + {1'b0, r_new};
        mid_new = lr_sum[SEG_AW:1];
    end

    // error window in the prediction's fixed point (16 or 17 fraction bits)
    logic [WIDE_W-1:0] err_wide;
    logic [WIDE_W-1:0] frac_mask;
    logic [WIDE_W-1:0] lo_q;
    logic [WIDE_W-1:0] up_q;
    logic              lo_pos, lo_big, up_neg, up_big;

    always_comb begin
        if (halve_mode_reg) begin
            err_wide  = WIDE_W'(error_bound_reg) << (FRAC_Q + 1);
            frac_mask = (WIDE_W'(1) << (FRAC_Q + 1)) - WIDE_W'(1);
            lo_q      = lo_reg >> (FRAC_Q + 1);
            up_q      = WIDE_W'($signed(acc_reg) >>> (FRAC_Q + 1));
        end else begin
            err_wide  = WIDE_W'(error_bound_reg) << FRAC_Q;
            frac_mask = (WIDE_W'(1) << FRAC_Q) - WIDE_W'(1);
            lo_q      = lo_reg >> FRAC_Q;
            up_q      = WIDE_W'($signed(acc_reg) >>> FRAC_Q);
        end
        lo_pos = !lo_reg[WIDE_W-1] && (lo_reg != '0);
        lo_big = (lo_q[WIDE_W-1:POS_W] != '0) || (lo_q[POS_W-1:0] >= pos_count_reg);
        up_neg = acc_reg[WIDE_W-1];
        up_big = (up_q[WIDE_W-1:POS_W] != '0) || (up_q[POS_W-1:0] >= pos_count_reg);
    end

    // state register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        mid_reg      <= mid_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        icpt_reg     <= icpt_next;
        mul_cnt_reg  <= mul_cnt_next;
        pp_reg       <= pp_next;
        pp_shift_reg <= pp_shift_next;
        acc_reg      <= acc_next;
        lo_reg       <= lo_next;
        res_low_reg  <= res_low_next;
        res_high_reg <= res_high_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        mid_next      = mid_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        icpt_next     = icpt_reg;
        mul_cnt_next  = mul_cnt_reg;
        pp_next       = pp_reg;
        pp_shift_next = pp_shift_reg;
        acc_next      = acc_reg;
        lo_next       = lo_reg;
        res_low_next  = res_low_reg;
        res_high_next = res_high_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_addr       = '0;
        arith_req     = '0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == OP_LOOKUP) begin
                    key_next   = in_lookup_key;
                    state_next = ST_CHECK;
                end
            end

            // bounds, then the first probe of the search
            ST_CHECK: begin
                if (key_reg > highest_key_reg) begin
                    res_low_next  = pos_count_reg;
                    res_high_next = pos_count_reg;
                    state_next    = ST_OUT;
                end else if (key_reg < lowest_key_reg) begin
                    res_low_next  = '0;
                    res_high_next = '0;
                    state_next    = ST_OUT;
                end else if (last_idx == SEG_AW'(1)) begin
                    // two entries: segment zero without a probe
                    left_next  = '0;
                    rd_addr    = '0;
                    state_next = ST_FETCH;
                end else begin
                    left_next  = '0;
                    right_next = last_idx;
                    mid_next   = last_idx >> 1;
                    rd_addr    = last_idx >> 1;
                    state_next = ST_SEARCH;
                end
            end

            // one probe per cycle; next address goes straight to the table
            ST_SEARCH: begin
                left_next  = l_new;
                right_next = r_new;
                if (SEG_AW'(l_new + SEG_AW'(1)) == r_new) begin
                    rd_addr    = l_new;
                    state_next = ST_FETCH;
                end else begin
                    mid_next = mid_new;
                    rd_addr  = mid_new;
                end
            end

            // chosen segment row is out of the table: split slope into sign and size
            ST_FETCH: begin
                neg_next     = rd_row.slope[KEY_W-1];
                mag_next     = rd_row.slope[KEY_W-1] ? KEY_W'(~rd_row.slope + KEY_W'(1))
                                                     : rd_row.slope;
                icpt_next    = rd_row.intercept;
                acc_next     = '0;
                mul_cnt_next = '0;
                state_next   = ST_MUL;
            end

            // four 32x32 partial products, each registered and added in the following cycle
            ST_MUL: begin
                arith_req.mul_a = mul_cnt_reg[1] ? key_reg[2*HALF_W-1:HALF_W]
                                                 : key_reg[HALF_W-1:0];
                arith_req.mul_b = mul_cnt_reg[0] ? mag_reg[2*HALF_W-1:HALF_W]
                                                 : mag_reg[HALF_W-1:0];
                arith_req.add_a = acc_reg;
                arith_req.add_b = WIDE_W'(pp_reg) << {pp_shift_reg, 5'b0};
                if (mul_cnt_reg != '0) begin
                    acc_next = arith_rsp.add_sum;
                end
                if (mul_cnt_reg == MUL_CNT_W'(MUL_STEPS)) begin
                    state_next = ST_NEG;
                end else begin
                    pp_next       = arith_rsp.mul_p;
                    pp_shift_next = 2'({1'b0, mul_cnt_reg[1]} + {1'b0, mul_cnt_reg[0]});
                    mul_cnt_next  = mul_cnt_reg + MUL_CNT_W'(1);
                end
            end

            // restore the slope sign
            ST_NEG: begin
                arith_req.add_a   = neg_reg ? ~acc_reg : acc_reg;
                arith_req.add_cin = neg_reg;
                acc_next          = arith_rsp.add_sum;
                state_next        = ST_SHADD;
            end

            // drop to 16 fraction bits (floor) and add the intercept
            ST_SHADD: begin
                arith_req.add_a = {{PROD_SHIFT{acc_reg[WIDE_W-1]}},
                                   acc_reg[WIDE_W-1:PROD_SHIFT]};
                arith_req.add_b = {{(WIDE_W-KEY_W){icpt_reg[KEY_W-1]}}, icpt_reg};
                acc_next        = arith_rsp.add_sum;
                state_next      = ST_LOWER;
            end

            ST_LOWER: begin
                arith_req.add_a   = acc_reg;
                arith_req.add_b   = ~err_wide;
                arith_req.add_cin = 1'b1;
                lo_next           = arith_rsp.add_sum;
                state_next        = ST_UPPER;
            end

            // low fraction bits of the error are zero, so the round-up mask ors in
            ST_UPPER: begin
                arith_req.add_a = acc_reg;
                arith_req.add_b = err_wide | frac_mask;
                acc_next        = arith_rsp.add_sum;
                state_next      = ST_CLAMP;
            end

            ST_CLAMP: begin
                state_next = ST_OUT;
                if (lo_pos && lo_big) begin
                    res_low_next  = pos_count_reg;
                    res_high_next = pos_count_reg;
                end else if (!lo_pos && pos_count_reg == '0) begin
                    res_low_next  = '0;
                    res_high_next = '0;
                end else begin
                    res_low_next = lo_pos ? lo_q[POS_W-1:0] : '0;
                    if (up_neg) begin
                        res_high_next = '0;
                    end else if (up_big) begin
                        res_high_next = pos_count_reg - POS_W'(1);
                    end else begin
                        res_high_next = up_q[POS_W-1:0];
                    end
                end
            end

            // hand the result to the output register once it is free
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {res_high_reg, res_low_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/plpl_seg_mem.sv @@
// segment table: start key, slope and intercept per row, one write and one read port
// depends on plpl_pkg
module plpl_seg_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [plpl_pkg::SEG_AW-1:0] wr_addr,
    input  plpl_pkg::seg_row_t          wr_row,
    input  logic [plpl_pkg::SEG_AW-1:0] rd_addr,
    output plpl_pkg::seg_row_t          rd_row
);
    import plpl_pkg::*;

    seg_row_t mem [MAX_SEGMENTS];
    seg_row_t rd_row_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    assign rd_row = rd_row_reg;

endmodule

@@ rtl/plpl_arith_unit.sv @@
// shared arithmetic unit: one 32x32 multiplier and one 128-bit adder with carry in
// depends on plpl_pkg
module plpl_arith_unit (
    input  plpl_pkg::arith_req_t req,
    output plpl_pkg::arith_rsp_t rsp
);
    import plpl_pkg::*;

    always_comb begin
        rsp.mul_p   = (2*HALF_W)'(req.mul_a) * (2*HALF_W)'(req.mul_b);
        rsp.add_sum = req.add_a + req.add_b + WIDE_W'(req.add_cin);
    end

endmodule
